[rtl/ffaa_pkg.sv]
//------------------------------------------------------------------------------
// ffaa_pkg: shared types and constants of the first-fit arena allocator
// Request and status codes, controller states and datapath commands, and the
// status bundle that the datapath returns to the controller.
//------------------------------------------------------------------------------
package ffaa_pkg;

  // Default geometry of the arena
  localparam int ARENA_GRANULES_DEF = 4096;
  localparam int HEADER_BYTES_DEF   = 48;

  // Fixed field widths
  localparam int SIZE_W   = 17;
  localparam int ADDR_W   = 16;
  localparam int COUNT_W  = 8;
  localparam int SIZE_G_W = 14;  // request size in granules, rounded up

  typedef enum logic [1:0] {
    ACT_ALLOC     = 2'd0,
    ACT_ALLOC_END = 2'd1,
    ACT_FREE      = 2'd2,
    ACT_REALLOC   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_FIT      = 2'd1,
    ST_INVALID     = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_CLR, S_INIT0, S_IDLE, S_DISP,
    S_AF_RD, S_AF_CHK, S_AF_NEW, S_AF_IT, S_LINK,
    S_AB_WRD, S_AB_WALK, S_AB_RD, S_AB_CHK, S_AB_NEW, S_AB_IT,
    S_A_DONE, S_A_FAIL, S_CK, S_CK_RES,
    S_FB_RG, S_FB_LG, S_FB_NX, S_FB_WG, S_FB_PV, S_FB_WPN,
    S_RG_CMP, S_RG_NX, S_RG_NNX, S_RG_NN, S_RG_G, S_FIN
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_INIT0, OP_ACCEPT,
    OP_AF_RD, OP_AF_CHK, OP_AF_NEW, OP_AF_IT, OP_LINK,
    OP_AB_RD, OP_AB_WALK, OP_AB_CHK, OP_AB_NEW, OP_AB_IT,
    OP_A_DONE, OP_A_FAIL, OP_CK, OP_CK_RES,
    OP_FB_RG, OP_FB_LG, OP_FB_NX, OP_FB_WG, OP_FB_PV, OP_FB_WPN,
    OP_RG_CMP, OP_RG_NX, OP_RG_NNX, OP_RG_NN, OP_RG_G, OP_FIN
  } op_e;

  typedef struct packed {
    act_e act;
    logic addr_zero;
    logic size_zero;
    logic fit;
    logic split_f;
    logic split_b;
    logic split_q;
    logic rnx_nil;
    logic rpv_nil;
    logic gnx_nil;
    logic gpv_nil;
    logic rd_fr;
    logic rd_mk;
    logic ck_bad;
    logic inplace;
    logic grow_ok;
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

[rtl/first_fit_arena_allocator.sv]
// Operation: a request is accepted, its search visits the headers one by one, then
//   splitting, freeing and merging steps follow before the result is delivered.
// Throughput: one transaction at a time; the list walk through the single
//   header memory port sets the rate.
// Reset: a clearing pass follows reset and every arena_bytes write; input is
//   stalled until it ends.
//------------------------------------------------------------------------------
// first_fit_arena_allocator: first-fit heap allocator with coalescing
// Allocates, frees and reallocates blocks of an address-ordered header list
// held in on-chip memory, with a wrapping count of failed allocations and null reallocate results.
//------------------------------------------------------------------------------
module first_fit_arena_allocator #(
  parameter int ARENA_GRANULES = ffaa_pkg::ARENA_GRANULES_DEF,
  parameter int HEADER_BYTES   = ffaa_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffaa_pkg::SIZE_W-1:0]   arena_bytes_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ffaa_pkg::act_e                action_i,
  input  logic [ffaa_pkg::SIZE_W-1:0]   size_bytes_i,
  input  logic [ffaa_pkg::ADDR_W-1:0]   address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ffaa_pkg::ADDR_W-1:0]   data_address_o,
  output ffaa_pkg::status_e             status_o,
  output logic [ffaa_pkg::COUNT_W-1:0]  failure_count_o
);

  ffaa_pkg::op_e  op;
  ffaa_pkg::sts_t sts;

  // Sequencer
  ffaa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .op_o       (op)
  );

  // Header store and arithmetic
  ffaa_dp #(
    .ARENA_GRANULES (ARENA_GRANULES),
    .HEADER_BYTES   (HEADER_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .arena_bytes_i   (arena_bytes_i),
    .action_i        (action_i),
    .size_bytes_i    (size_bytes_i),
    .address_i       (address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .data_address_o  (data_address_o),
    .status_o        (status_o),
    .failure_count_o (failure_count_o)
  );

endmodule

[rtl/ffaa_ctrl.sv]
//------------------------------------------------------------------------------
// ffaa_ctrl: request sequencer
// Walks each request through list traversal, split, free and merge steps and
// issues at most one datapath command per cycle; it holds in the delivery state until the output register is free.
//------------------------------------------------------------------------------
module ffaa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ffaa_pkg::sts_t  sts_i,
  output ffaa_pkg::op_e   op_o
);

  ffaa_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffaa_pkg::S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  // Take a new transaction only when idle and no arena write is pending
  assign in_stall_o = (state_q != ffaa_pkg::S_IDLE) || cfg_we_i;

  // Next state and command
  always_comb begin
    state_d = state_q;
    op_o    = ffaa_pkg::OP_NONE;
    unique case (state_q)
      ffaa_pkg::S_CLR: begin
        op_o = ffaa_pkg::OP_CLR;
        if (sts_i.clr_last) state_d = ffaa_pkg::S_INIT0;
      end
      ffaa_pkg::S_INIT0: begin
        op_o    = ffaa_pkg::OP_INIT0;
        state_d = ffaa_pkg::S_IDLE;
      end
      ffaa_pkg::S_IDLE: begin
        if (in_valid_i && !cfg_we_i) begin
          op_o    = ffaa_pkg::OP_ACCEPT;
          state_d = ffaa_pkg::S_DISP;
        end
      end
      ffaa_pkg::S_DISP: begin
        unique case (sts_i.act)
          ffaa_pkg::ACT_ALLOC:     state_d = ffaa_pkg::S_AF_RD;
          ffaa_pkg::ACT_ALLOC_END: state_d = ffaa_pkg::S_AB_WRD;
          ffaa_pkg::ACT_FREE:
            state_d = sts_i.addr_zero ? ffaa_pkg::S_FIN : ffaa_pkg::S_CK;
          default:
            state_d = sts_i.addr_zero ? ffaa_pkg::S_AF_RD : ffaa_pkg::S_CK;
        endcase
      end
      // Front search
      ffaa_pkg::S_AF_RD: begin
        op_o    = ffaa_pkg::OP_AF_RD;
        state_d = ffaa_pkg::S_AF_CHK;
      end
      ffaa_pkg::S_AF_CHK: begin
        op_o = ffaa_pkg::OP_AF_CHK;
        if (sts_i.fit) begin
          state_d = sts_i.split_f ? ffaa_pkg::S_AF_NEW : ffaa_pkg::S_AF_IT;
        end else begin
          state_d = sts_i.rnx_nil ? ffaa_pkg::S_A_FAIL : ffaa_pkg::S_AF_RD;
        end
      end
      ffaa_pkg::S_AF_NEW: begin
        op_o    = ffaa_pkg::OP_AF_NEW;
        state_d = ffaa_pkg::S_AF_IT;
      end
      ffaa_pkg::S_AF_IT: begin
        op_o    = ffaa_pkg::OP_AF_IT;
        state_d = (sts_i.split_q && !sts_i.rnx_nil) ? ffaa_pkg::S_LINK
                                                    : ffaa_pkg::S_A_DONE;
      end
      ffaa_pkg::S_LINK: begin
        op_o    = ffaa_pkg::OP_LINK;
        state_d = ffaa_pkg::S_A_DONE;
      end
      // Tail walk, then backward search
      ffaa_pkg::S_AB_WRD: begin
        op_o    = ffaa_pkg::OP_AB_RD;
        state_d = ffaa_pkg::S_AB_WALK;
      end
      ffaa_pkg::S_AB_WALK: begin
        op_o    = ffaa_pkg::OP_AB_WALK;
        state_d = sts_i.rnx_nil ? ffaa_pkg::S_AB_CHK : ffaa_pkg::S_AB_WRD;
      end
      ffaa_pkg::S_AB_RD: begin
        op_o    = ffaa_pkg::OP_AB_RD;
        state_d = ffaa_pkg::S_AB_CHK;
      end
      ffaa_pkg::S_AB_CHK: begin
        op_o = ffaa_pkg::OP_AB_CHK;
        if (sts_i.fit) begin
          state_d = sts_i.split_b ? ffaa_pkg::S_AB_NEW : ffaa_pkg::S_AB_IT;
        end else begin
          state_d = sts_i.rpv_nil ? ffaa_pkg::S_A_FAIL : ffaa_pkg::S_AB_RD;
        end
      end
      ffaa_pkg::S_AB_NEW: begin
        op_o    = ffaa_pkg::OP_AB_NEW;
        state_d = ffaa_pkg::S_AB_IT;
      end
      ffaa_pkg::S_AB_IT: begin
        op_o    = ffaa_pkg::OP_AB_IT;
        state_d = (sts_i.split_q && !sts_i.rnx_nil) ? ffaa_pkg::S_LINK
                                                    : ffaa_pkg::S_A_DONE;
      end
      // Allocation outcome; a moving reallocate frees the old block next
      ffaa_pkg::S_A_DONE: begin
        op_o    = ffaa_pkg::OP_A_DONE;
        state_d = (sts_i.act == ffaa_pkg::ACT_REALLOC && !sts_i.addr_zero)
                  ? ffaa_pkg::S_FB_RG : ffaa_pkg::S_FIN;
      end
      ffaa_pkg::S_A_FAIL: begin
        op_o    = ffaa_pkg::OP_A_FAIL;
        state_d = ffaa_pkg::S_FIN;
      end
      // Header check
      ffaa_pkg::S_CK: begin
        op_o    = ffaa_pkg::OP_CK;
        state_d = sts_i.ck_bad ? ffaa_pkg::S_FIN : ffaa_pkg::S_CK_RES;
      end
      ffaa_pkg::S_CK_RES: begin
        op_o = ffaa_pkg::OP_CK_RES;
        if (!sts_i.rd_mk || sts_i.rd_fr) begin
          state_d = ffaa_pkg::S_FIN;
        end else if (sts_i.act == ffaa_pkg::ACT_FREE || sts_i.size_zero) begin
          state_d = ffaa_pkg::S_FB_LG;
        end else begin
          state_d = ffaa_pkg::S_RG_CMP;
        end
      end
      // Free and merge
      ffaa_pkg::S_FB_RG: begin
        op_o    = ffaa_pkg::OP_FB_RG;
        state_d = ffaa_pkg::S_FB_LG;
      end
      ffaa_pkg::S_FB_LG: begin
        op_o    = ffaa_pkg::OP_FB_LG;
        state_d = sts_i.rnx_nil ? ffaa_pkg::S_FB_WG : ffaa_pkg::S_FB_NX;
      end
      ffaa_pkg::S_FB_NX: begin
        op_o    = ffaa_pkg::OP_FB_NX;
        state_d = ffaa_pkg::S_FB_WG;
      end
      ffaa_pkg::S_FB_WG: begin
        op_o    = ffaa_pkg::OP_FB_WG;
        state_d = sts_i.gpv_nil ? ffaa_pkg::S_FIN : ffaa_pkg::S_FB_PV;
      end
      ffaa_pkg::S_FB_PV: begin
        op_o    = ffaa_pkg::OP_FB_PV;
        state_d = (sts_i.rd_fr && !sts_i.gnx_nil) ? ffaa_pkg::S_FB_WPN
                                                  : ffaa_pkg::S_FIN;
      end
      ffaa_pkg::S_FB_WPN: begin
        op_o    = ffaa_pkg::OP_FB_WPN;
        state_d = ffaa_pkg::S_FIN;
      end
      // Reallocate: in place, grow into successor, or move
      ffaa_pkg::S_RG_CMP: begin
        op_o = ffaa_pkg::OP_RG_CMP;
        if (sts_i.inplace) begin
          state_d = ffaa_pkg::S_FIN;
        end else begin
          state_d = sts_i.gnx_nil ? ffaa_pkg::S_AF_RD : ffaa_pkg::S_RG_NX;
        end
      end
      ffaa_pkg::S_RG_NX: begin
        op_o = ffaa_pkg::OP_RG_NX;
        if (sts_i.grow_ok) begin
          state_d = sts_i.rnx_nil ? ffaa_pkg::S_RG_NN : ffaa_pkg::S_RG_NNX;
        end else begin
          state_d = ffaa_pkg::S_AF_RD;
        end
      end
      ffaa_pkg::S_RG_NNX: begin
        op_o    = ffaa_pkg::OP_RG_NNX;
        state_d = ffaa_pkg::S_RG_NN;
      end
      ffaa_pkg::S_RG_NN: begin
        op_o    = ffaa_pkg::OP_RG_NN;
        state_d = ffaa_pkg::S_RG_G;
      end
      ffaa_pkg::S_RG_G: begin
        op_o    = ffaa_pkg::OP_RG_G;
        state_d = ffaa_pkg::S_FIN;
      end
      // Deliver once the output register is free
      ffaa_pkg::S_FIN: begin
        if (sts_i.out_free) begin
          op_o    = ffaa_pkg::OP_FIN;
          state_d = ffaa_pkg::S_IDLE;
        end
      end
      default: state_d = ffaa_pkg::S_CLR;
    endcase
    if (cfg_we_i) state_d = ffaa_pkg::S_CLR;
  end

endmodule

[rtl/ffaa_dp.sv]
//------------------------------------------------------------------------------
// ffaa_dp: header store and arithmetic of the arena allocator
// Holds the header memories, the request registers, the walk pointers and
// the output register, and carries out one controller command per cycle.
//------------------------------------------------------------------------------
module ffaa_dp #(
  parameter int ARENA_GRANULES = ffaa_pkg::ARENA_GRANULES_DEF,
  parameter int HEADER_BYTES   = ffaa_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffaa_pkg::op_e                 op_i,
  output ffaa_pkg::sts_t                sts_o,
  input  logic                          cfg_we_i,
  input  logic [ffaa_pkg::SIZE_W-1:0]   arena_bytes_i,
  input  ffaa_pkg::act_e                action_i,
  input  logic [ffaa_pkg::SIZE_W-1:0]   size_bytes_i,
  input  logic [ffaa_pkg::ADDR_W-1:0]   address_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ffaa_pkg::ADDR_W-1:0]   data_address_o,
  output ffaa_pkg::status_e             status_o,
  output logic [ffaa_pkg::COUNT_W-1:0]  failure_count_o
);

  localparam int AW    = $clog2(ARENA_GRANULES);
  localparam int LW    = AW + 1;
  localparam int SW    = ffaa_pkg::SIZE_G_W;
  localparam int CW    = ((LW > SW) ? LW : SW) + 2;
  localparam int HDR_G = (HEADER_BYTES + 15) / 16;

  localparam logic [LW-1:0] NIL   = LW'(ARENA_GRANULES);
  localparam logic [CW-1:0] NIL_C = CW'(ARENA_GRANULES);
  localparam logic [CW-1:0] HDR_C = CW'(HDR_G);
  localparam logic [ffaa_pkg::ADDR_W-1:0] HDR_BYTES_C = ffaa_pkg::ADDR_W'(HDR_G * 16);

  // Header memories
  logic          mk_m [ARENA_GRANULES];
  logic          fr_m [ARENA_GRANULES];
  logic [LW-1:0] sz_m [ARENA_GRANULES];
  logic [LW-1:0] nx_m [ARENA_GRANULES];
  logic [LW-1:0] pv_m [ARENA_GRANULES];

  logic          rd_mk_q, rd_fr_q;
  logic [LW-1:0] rd_sz_q, rd_nx_q, rd_pv_q;

  // Request and walk registers
  ffaa_pkg::act_e           act_q;
  logic [SW-1:0]            s_q;
  logic [ffaa_pkg::ADDR_W-1:0] addr_q;
  logic                     szz_q;
  logic [LW-1:0]            it_q, n_q, ng_q, g_q, gsz_q, gnx_q, gpv_q;
  logic                     split_q;
  logic [ffaa_pkg::ADDR_W-1:0] data_q;
  ffaa_pkg::status_e        st_q;
  logic                     null_q;
  logic [ffaa_pkg::COUNT_W-1:0] fail_q;
  logic [ffaa_pkg::SIZE_W-1:0]  arena_q;
  logic [AW-1:0]            clr_q;

  // Output register
  logic                     out_valid_q;
  logic [ffaa_pkg::ADDR_W-1:0] out_data_q;
  ffaa_pkg::status_e        out_st_q;
  logic [ffaa_pkg::COUNT_W-1:0] out_fail_q;

  // Memory port controls
  logic          ren;
  logic [AW-1:0] raddr, waddr;
  logic          we_mk, we_fr, we_sz, we_nx, we_pv;
  logic          w_mk, w_fr;
  logic [LW-1:0] w_sz, w_nx, w_pv;

  // Arithmetic on the current header and the request
  logic [CW-1:0] s_c, it_c, sz_c, gsz_c, gnx_c, need_c, nf_c, nb_c;
  logic [CW-1:0] q_c, diff_c, nn_c, nsz_c, gr_c, ng_c, fail_sz_c;
  logic          fit, split_f, split_b, ck_bad, inplace, grow_ok, out_free;
  logic [ffaa_pkg::COUNT_W-1:0] fail_next;

  always_comb begin
    s_c    = CW'(s_q);
    it_c   = CW'(it_q);
    sz_c   = CW'(rd_sz_q);
    gsz_c  = CW'(gsz_q);
    gnx_c  = CW'(gnx_q);
    need_c = s_c + HDR_C;
    fit    = rd_fr_q && (sz_c >= s_c);
    nf_c   = it_c + need_c;
    nb_c   = it_c + sz_c - s_c;
    split_f = (need_c < sz_c) && (nf_c < NIL_C);
    split_b = (need_c < sz_c) && (nb_c < NIL_C);
    fail_sz_c = sz_c - need_c;
    // Header check of a data offset
    q_c    = CW'(addr_q >> 4) - HDR_C;
    ck_bad = (addr_q < HDR_BYTES_C) || (addr_q[3:0] != 4'd0) || (q_c >= NIL_C);
    // Growth into the successor
    inplace = s_c <= gsz_c;
    diff_c  = s_c - gsz_c;
    nn_c    = gnx_c + diff_c;
    nsz_c   = sz_c - diff_c;
    grow_ok = rd_fr_q && (sz_c >= diff_c) && (nn_c < NIL_C);
    // Arena size clamped to header .. store size
    gr_c = CW'(arena_q >> 4);
    if (gr_c > NIL_C) gr_c = NIL_C;
    if (gr_c < HDR_C) gr_c = HDR_C;
    ng_c = CW'(ng_q) + HDR_C;
    out_free  = !out_valid_q || !out_stall_i;
    fail_next = fail_q + ffaa_pkg::COUNT_W'(act_q == ffaa_pkg::ACT_REALLOC && null_q);
  end

  // Memory read and write selection
  always_comb begin
    ren   = 1'b0;
    raddr = '0;
    waddr = '0;
    we_mk = 1'b0; we_fr = 1'b0; we_sz = 1'b0; we_nx = 1'b0; we_pv = 1'b0;
    w_mk  = 1'b0; w_fr  = 1'b0;
    w_sz  = '0;   w_nx  = '0;   w_pv  = '0;
    unique case (op_i)
      ffaa_pkg::OP_CLR: begin
        waddr = clr_q;
        we_mk = 1'b1;
      end
      ffaa_pkg::OP_INIT0: begin
        we_mk = 1'b1; we_fr = 1'b1; we_sz = 1'b1; we_nx = 1'b1; we_pv = 1'b1;
        w_mk  = 1'b1; w_fr  = 1'b1;
        w_sz  = LW'(gr_c - HDR_C);
        w_nx  = NIL;
        w_pv  = NIL;
      end
      ffaa_pkg::OP_AF_RD, ffaa_pkg::OP_AB_RD: begin
        ren   = 1'b1;
        raddr = it_q[AW-1:0];
      end
      ffaa_pkg::OP_AF_NEW: begin
        waddr = n_q[AW-1:0];
        we_mk = 1'b1; we_fr = 1'b1; we_sz = 1'b1; we_nx = 1'b1; we_pv = 1'b1;
        w_mk  = 1'b1; w_fr  = 1'b1;
        w_sz  = LW'(fail_sz_c);
        w_nx  = rd_nx_q;
        w_pv  = it_q;
      end
      ffaa_pkg::OP_AF_IT: begin
        waddr = it_q[AW-1:0];
        we_fr = 1'b1;
        we_sz = split_q;
        we_nx = split_q;
        w_sz  = LW'(s_c);
        w_nx  = n_q;
      end
      ffaa_pkg::OP_LINK, ffaa_pkg::OP_RG_NNX: begin
        waddr = rd_nx_q[AW-1:0];
        we_pv = 1'b1;
        w_pv  = n_q;
      end
      ffaa_pkg::OP_AB_NEW: begin
        waddr = n_q[AW-1:0];
        we_mk = 1'b1; we_fr = 1'b1; we_sz = 1'b1; we_nx = 1'b1; we_pv = 1'b1;
        w_mk  = 1'b1;
        w_sz  = LW'(s_c);
        w_nx  = rd_nx_q;
        w_pv  = it_q;
      end
      ffaa_pkg::OP_AB_IT: begin
        // Split keeps the lower part free; otherwise take the whole block
        waddr = it_q[AW-1:0];
        we_fr = !split_q;
        we_sz = split_q;
        we_nx = split_q;
        w_sz  = LW'(fail_sz_c);
        w_nx  = n_q;
      end
      ffaa_pkg::OP_CK: begin
        ren   = !ck_bad;
        raddr = q_c[AW-1:0];
      end
      ffaa_pkg::OP_FB_RG: begin
        ren   = 1'b1;
        raddr = g_q[AW-1:0];
      end
      ffaa_pkg::OP_FB_LG: begin
        ren   = (rd_nx_q != NIL);
        raddr = rd_nx_q[AW-1:0];
      end
      ffaa_pkg::OP_FB_NX: begin
        waddr = rd_nx_q[AW-1:0];
        we_pv = rd_fr_q && (rd_nx_q != NIL);
        w_pv  = g_q;
      end
      ffaa_pkg::OP_FB_WG: begin
        waddr = g_q[AW-1:0];
        we_fr = 1'b1; we_sz = 1'b1; we_nx = 1'b1;
        w_fr  = 1'b1;
        w_sz  = gsz_q;
        w_nx  = gnx_q;
        ren   = (gpv_q != NIL);
        raddr = gpv_q[AW-1:0];
      end
      ffaa_pkg::OP_FB_PV: begin
        waddr = gpv_q[AW-1:0];
        we_sz = rd_fr_q;
        we_nx = rd_fr_q;
        w_sz  = LW'(sz_c + gsz_c + HDR_C);
        w_nx  = gnx_q;
      end
      ffaa_pkg::OP_FB_WPN: begin
        waddr = gnx_q[AW-1:0];
        we_pv = 1'b1;
        w_pv  = gpv_q;
      end
      ffaa_pkg::OP_RG_CMP: begin
        ren   = !inplace && (gnx_q != NIL);
        raddr = gnx_q[AW-1:0];
      end
      ffaa_pkg::OP_RG_NX: begin
        waddr = gnx_q[AW-1:0];
        we_sz = grow_ok;
        w_sz  = LW'(nsz_c);
      end
      ffaa_pkg::OP_RG_NN: begin
        waddr = n_q[AW-1:0];
        we_mk = 1'b1; we_fr = 1'b1; we_sz = 1'b1; we_nx = 1'b1; we_pv = 1'b1;
        w_mk  = 1'b1; w_fr  = 1'b1;
        w_sz  = LW'(nsz_c);
        w_nx  = rd_nx_q;
        w_pv  = rd_pv_q;
      end
      ffaa_pkg::OP_RG_G: begin
        waddr = g_q[AW-1:0];
        we_sz = 1'b1; we_nx = 1'b1;
        w_sz  = LW'(s_c);
        w_nx  = n_q;
      end
      default: begin
      end
    endcase
  end

  // Header memories: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_mk) mk_m[waddr] <= w_mk;
    if (we_fr) fr_m[waddr] <= w_fr;
    if (we_sz) sz_m[waddr] <= w_sz;
    if (we_nx) nx_m[waddr] <= w_nx;
    if (we_pv) pv_m[waddr] <= w_pv;
    if (ren) begin
      rd_mk_q <= mk_m[raddr];
      rd_fr_q <= fr_m[raddr];
      rd_sz_q <= sz_m[raddr];
      rd_nx_q <= nx_m[raddr];
      rd_pv_q <= pv_m[raddr];
    end
  end

  // Control registers: arena size, clear sweep, failure count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q     <= ffaa_pkg::SIZE_W'(65536);
      clr_q       <= '0;
      fail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        arena_q <= arena_bytes_i;
        clr_q   <= '0;
      end else if (op_i == ffaa_pkg::OP_CLR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (op_i == ffaa_pkg::OP_A_FAIL) begin
        fail_q <= fail_q + ffaa_pkg::COUNT_W'(1);
      end else if (op_i == ffaa_pkg::OP_FIN) begin
        fail_q <= fail_next;
      end
      if (op_i == ffaa_pkg::OP_FIN) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      ffaa_pkg::OP_ACCEPT: begin
        act_q  <= action_i;
        s_q    <= SW'((18'(size_bytes_i) + 18'd15) >> 4);
        addr_q <= address_i;
        szz_q  <= (size_bytes_i == '0);
        it_q   <= '0;
        st_q   <= ffaa_pkg::ST_OK;
        null_q <= 1'b1;
        data_q <= '0;
      end
      ffaa_pkg::OP_AF_CHK: begin
        if (fit) begin
          split_q <= split_f;
          n_q     <= LW'(nf_c);
          ng_q    <= it_q;
        end else begin
          it_q <= rd_nx_q;
        end
      end
      ffaa_pkg::OP_AB_WALK: begin
        if (rd_nx_q != NIL) it_q <= rd_nx_q;
      end
      ffaa_pkg::OP_AB_CHK: begin
        if (fit) begin
          split_q <= split_b;
          n_q     <= LW'(nb_c);
          ng_q    <= split_b ? LW'(nb_c) : it_q;
        end else begin
          it_q <= rd_pv_q;
        end
      end
      ffaa_pkg::OP_A_DONE: begin
        data_q <= {ng_c[11:0], 4'd0};
        null_q <= 1'b0;
      end
      ffaa_pkg::OP_A_FAIL: st_q <= ffaa_pkg::ST_NO_FIT;
      ffaa_pkg::OP_CK: begin
        if (ck_bad) st_q <= ffaa_pkg::ST_INVALID;
        g_q <= LW'(q_c);
      end
      ffaa_pkg::OP_CK_RES: begin
        st_q  <= !rd_mk_q ? ffaa_pkg::ST_INVALID
               : rd_fr_q  ? ffaa_pkg::ST_DOUBLE_FREE : ffaa_pkg::ST_OK;
        gsz_q <= rd_sz_q;
        gnx_q <= rd_nx_q;
        gpv_q <= rd_pv_q;
      end
      ffaa_pkg::OP_FB_LG: begin
        gsz_q <= rd_sz_q;
        gnx_q <= rd_nx_q;
        gpv_q <= rd_pv_q;
      end
      ffaa_pkg::OP_FB_NX: begin
        // Absorb a free successor
        if (rd_fr_q) begin
          gsz_q <= LW'(gsz_c + sz_c + HDR_C);
          gnx_q <= rd_nx_q;
        end
      end
      ffaa_pkg::OP_RG_CMP: begin
        it_q <= '0;
        if (inplace) begin
          data_q <= addr_q;
          null_q <= 1'b0;
        end
      end
      ffaa_pkg::OP_RG_NX: begin
        if (grow_ok) n_q <= LW'(nn_c);
      end
      ffaa_pkg::OP_RG_G: begin
        data_q <= addr_q;
        null_q <= 1'b0;
      end
      ffaa_pkg::OP_FIN: begin
        out_data_q <= data_q;
        out_st_q   <= st_q;
        out_fail_q <= fail_next;
      end
      default: begin
      end
    endcase
  end

  // Status back to the controller
  always_comb begin
    sts_o.act       = act_q;
    sts_o.addr_zero = (addr_q == '0);
    sts_o.size_zero = szz_q;
    sts_o.fit       = fit;
    sts_o.split_f   = split_f;
    sts_o.split_b   = split_b;
    sts_o.split_q   = split_q;
    sts_o.rnx_nil   = (rd_nx_q == NIL);
    sts_o.rpv_nil   = (rd_pv_q == NIL);
    sts_o.gnx_nil   = (gnx_q == NIL);
    sts_o.gpv_nil   = (gpv_q == NIL);
    sts_o.rd_fr     = rd_fr_q;
    sts_o.rd_mk     = rd_mk_q;
    sts_o.ck_bad    = ck_bad;
    sts_o.inplace   = inplace;
    sts_o.grow_ok   = grow_ok;
    sts_o.clr_last  = (clr_q == AW'(ARENA_GRANULES - 1));
    sts_o.out_free  = out_free;
  end

  assign out_valid_o     = out_valid_q;
  assign data_address_o  = out_data_q;
  assign status_o        = out_st_q;
  assign failure_count_o = out_fail_q;

`ifndef SYNTHESIS
  // Never read and write the same header in one cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ren && (we_mk || we_fr || we_sz || we_nx || we_pv)) |-> (raddr != waddr))
    else $error("header read and write collide");

  // Deliver only into a free output register
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == ffaa_pkg::OP_FIN) |-> out_free)
    else $error("result overwrites a pending transaction");

  // The walk pointer is a real header whenever it is read
  a_walk_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == ffaa_pkg::OP_AF_RD || op_i == ffaa_pkg::OP_AB_RD) |-> (it_q < NIL))
    else $error("walk pointer past the list");

  // A failed search bumps the failure count by one
  a_fail_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == ffaa_pkg::OP_A_FAIL) |=>
      (fail_q == $past(fail_q) + ffaa_pkg::COUNT_W'(1)))
    else $error("failure count not advanced");
`endif

endmodule

[test/ffaa_checker.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// ffaa_checker: result predictor and scoreboard for the arena allocator
// Watches the configuration port and both channels, keeps its own copy of the
// header list, predicts each result and compares it field by field.
//------------------------------------------------------------------------------
module ffaa_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ffaa_pkg::SIZE_W-1:0]   arena_bytes_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  ffaa_pkg::act_e                action_i,
  input  logic [ffaa_pkg::SIZE_W-1:0]   size_bytes_i,
  input  logic [ffaa_pkg::ADDR_W-1:0]   address_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [ffaa_pkg::ADDR_W-1:0]   data_address_i,
  input  ffaa_pkg::status_e             status_i,
  input  logic [ffaa_pkg::COUNT_W-1:0]  failure_count_i,
  output int                            error_count_o,
  output int                            pending_o
);

  localparam int unsigned GRAN  = ffaa_pkg::ARENA_GRANULES_DEF;
  localparam int unsigned HDR_G = (ffaa_pkg::HEADER_BYTES_DEF + 15) / 16;
  localparam int unsigned NIL   = GRAN;

  typedef struct {
    logic [ffaa_pkg::ADDR_W-1:0]  data;
    ffaa_pkg::status_e            status;
    logic [ffaa_pkg::COUNT_W-1:0] count;
  } alloc_result_t;

  // Shadow copy of the header store
  bit          hdr_mark [GRAN];
  bit          blk_free [GRAN];
  int unsigned blk_size [GRAN];
  int unsigned nxt_hdr  [GRAN];
  int unsigned prv_hdr  [GRAN];
  logic [ffaa_pkg::COUNT_W-1:0] fail_cnt;
  int unsigned arena_cfg;

  alloc_result_t expected_results[$];
  int errors;

  assign error_count_o = errors;

  function automatic void format_arena();
    int unsigned gr;
    gr = arena_cfg >> 4;
    if (gr > GRAN) gr = GRAN;
    if (gr < HDR_G) gr = HDR_G;
    for (int i = 0; i < GRAN; i++) begin
      hdr_mark[i] = 0;
      blk_free[i] = 0;
      blk_size[i] = 0;
      nxt_hdr[i]  = 0;
      prv_hdr[i]  = 0;
    end
    hdr_mark[0] = 1;
    blk_free[0] = 1;
    blk_size[0] = gr - HDR_G;
    nxt_hdr[0]  = NIL;
    prv_hdr[0]  = NIL;
  endfunction

  function automatic void place_header(int unsigned g, int unsigned sz, int unsigned nx,
                                       int unsigned pv, bit fr);
    hdr_mark[g] = 1;
    blk_free[g] = fr;
    blk_size[g] = sz;
    nxt_hdr[g]  = nx;
    prv_hdr[g]  = pv;
  endfunction

  // First fit from the head of the list; split off the remainder
  function automatic int unsigned carve_front(int unsigned s);
    int unsigned it, steps, sz, n;
    it = 0;
    steps = 0;
    while (it < NIL && steps <= NIL) begin
      steps++;
      sz = blk_size[it];
      if (blk_free[it] && sz >= s) begin
        n = it + s + HDR_G;
        if (s + HDR_G < sz && n < NIL) begin
          place_header(n, sz - (s + HDR_G), nxt_hdr[it], it, 1'b1);
          nxt_hdr[it] = n;
          blk_size[it] = s;
          if (nxt_hdr[n] < NIL) prv_hdr[nxt_hdr[n]] = n;
        end
        blk_free[it] = 0;
        return it;
      end
      it = nxt_hdr[it];
    end
    return NIL;
  endfunction

  // First fit from the tail; carve the data off the top of the block
  function automatic int unsigned carve_back(int unsigned s);
    int unsigned it, steps, sz, n;
    it = 0;
    steps = 0;
    while (nxt_hdr[it] < NIL && steps <= NIL) begin
      steps++;
      it = nxt_hdr[it];
    end
    steps = 0;
    while (it < NIL && steps <= NIL) begin
      steps++;
      sz = blk_size[it];
      if (blk_free[it] && sz >= s) begin
        n = it + sz - s;
        if (s + HDR_G < sz && n < NIL) begin
          place_header(n, s, nxt_hdr[it], it, 1'b0);
          nxt_hdr[it] = n;
          blk_size[it] = sz - (s + HDR_G);
          if (nxt_hdr[n] < NIL) prv_hdr[nxt_hdr[n]] = n;
          it = n;
        end
        blk_free[it] = 0;
        return it;
      end
      it = prv_hdr[it];
    end
    return NIL;
  endfunction

  function automatic ffaa_pkg::status_e check_header(int unsigned addr,
                                                     output int unsigned g);
    int unsigned q;
    g = 0;
    if (addr < HDR_G * 16 || (addr & 15) != 0) return ffaa_pkg::ST_INVALID;
    q = (addr >> 4) - HDR_G;
    if (q >= NIL || !hdr_mark[q]) return ffaa_pkg::ST_INVALID;
    g = q;
    return blk_free[q] ? ffaa_pkg::ST_DOUBLE_FREE : ffaa_pkg::ST_OK;
  endfunction

  // Mark free and merge with free neighbors
  function automatic void release_block(int unsigned g);
    int unsigned nx, pv, nn;
    nx = nxt_hdr[g];
    pv = prv_hdr[g];
    blk_free[g] = 1;
    if (nx < NIL && blk_free[nx]) begin
      nn = nxt_hdr[nx];
      if (nn < NIL) prv_hdr[nn] = g;
      blk_size[g] += blk_size[nx] + HDR_G;
      nxt_hdr[g] = nn;
    end
    if (pv < NIL && blk_free[pv]) begin
      blk_size[pv] += blk_size[g] + HDR_G;
      nxt_hdr[pv] = nxt_hdr[g];
      if (nxt_hdr[g] < NIL) prv_hdr[nxt_hdr[g]] = pv;
    end
  endfunction

  function automatic logic [ffaa_pkg::ADDR_W-1:0] data_offset(int unsigned g);
    return ffaa_pkg::ADDR_W'((g + HDR_G) << 4);
  endfunction

  function automatic alloc_result_t serve_request(ffaa_pkg::act_e act, int unsigned size,
                                                  int unsigned addr);
    alloc_result_t r;
    int unsigned s, g, ng, cur, nx, diff, nn, nsz, nnx, npv;
    bit null_res;
    s = (size + 15) >> 4;
    r.data = '0;
    r.status = ffaa_pkg::ST_OK;
    null_res = 1;
    g = 0;
    case (act)
      ffaa_pkg::ACT_ALLOC, ffaa_pkg::ACT_ALLOC_END: begin
        ng = (act == ffaa_pkg::ACT_ALLOC) ? carve_front(s) : carve_back(s);
        if (ng == NIL) begin
          r.status = ffaa_pkg::ST_NO_FIT;
          fail_cnt++;
        end else r.data = data_offset(ng);
      end
      ffaa_pkg::ACT_FREE: begin
        if (addr != 0) begin
          r.status = check_header(addr, g);
          if (r.status == ffaa_pkg::ST_OK) release_block(g);
        end
      end
      default: begin
        if (addr == 0) begin
          ng = carve_front(s);
          if (ng == NIL) begin
            r.status = ffaa_pkg::ST_NO_FIT;
            fail_cnt++;
          end else begin
            r.data = data_offset(ng);
            null_res = 0;
          end
        end else if (size == 0) begin
          r.status = check_header(addr, g);
          if (r.status == ffaa_pkg::ST_OK) release_block(g);
        end else begin
          r.status = check_header(addr, g);
          if (r.status == ffaa_pkg::ST_OK) begin
            cur = blk_size[g];
            if (s <= cur) begin
              r.data = ffaa_pkg::ADDR_W'(addr);
              null_res = 0;
            end else begin
              nx = nxt_hdr[g];
              diff = s - cur;
              if (nx < NIL && blk_free[nx] && blk_size[nx] >= diff && nx + diff < NIL) begin
                // Grow in place into the free successor
                nn = nx + diff;
                nsz = blk_size[nx] - diff;
                nnx = nxt_hdr[nx];
                npv = prv_hdr[nx];
                blk_size[nx] = nsz;
                if (nnx < NIL) prv_hdr[nnx] = nn;
                place_header(nn, nsz, nnx, npv, 1'b1);
                nxt_hdr[g] = nn;
                blk_size[g] = s;
                r.data = ffaa_pkg::ADDR_W'(addr);
                null_res = 0;
              end else begin
                ng = carve_front(s);
                if (ng == NIL) begin
                  r.status = ffaa_pkg::ST_NO_FIT;
                  fail_cnt++;
                end else begin
                  release_block(g);
                  r.data = data_offset(ng);
                  null_res = 0;
                end
              end
            end
          end
        end
        if (null_res) fail_cnt++;
      end
    endcase
    r.count = fail_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("%0t checker: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      arena_cfg = 65536;
      fail_cnt = '0;
      format_arena();
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_we_i) begin
        arena_cfg = arena_bytes_i;
        format_arena();
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(serve_request(action_i, size_bytes_i, address_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction, data_address", data_address_i, 0);
        end else begin
          want = expected_results.pop_front();
          if (data_address_i !== want.data)
            report_mismatch("data_address", data_address_i, want.data);
          if (status_i !== want.status)
            report_mismatch("status", status_i, want.status);
          if (failure_count_i !== want.count)
            report_mismatch("failure_count", failure_count_i, want.count);
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// testbench: stimulus and verdict for the first-fit arena allocator
// Runs a directed request sequence, then random allocate, free and reallocate
// traffic over several arena sizes, with bursty input and a stalling receiver.
//------------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 50000;
  localparam int PHASE_ITEMS    = 230;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [ffaa_pkg::SIZE_W-1:0]  arena_bytes = 17'd65536;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  ffaa_pkg::act_e               action = ffaa_pkg::ACT_ALLOC;
  logic [ffaa_pkg::SIZE_W-1:0]  size_bytes = '0;
  logic [ffaa_pkg::ADDR_W-1:0]  address = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [ffaa_pkg::ADDR_W-1:0]  data_address;
  ffaa_pkg::status_e            status;
  logic [ffaa_pkg::COUNT_W-1:0] failure_count;

  int error_count, pending;
  int burst_left = 0;
  int idle_cycles = 0;
  int unsigned cyc = 0;
  logic [ffaa_pkg::ADDR_W-1:0] live_blocks[$];

  always #6 clk_i = ~clk_i;

  first_fit_arena_allocator dut (
    .clk_i, .rst_ni,
    .cfg_we_i        (cfg_we),
    .arena_bytes_i   (arena_bytes),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (action),
    .size_bytes_i    (size_bytes),
    .address_i       (address),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .data_address_o  (data_address),
    .status_o        (status),
    .failure_count_o (failure_count)
  );

  ffaa_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i        (cfg_we),
    .arena_bytes_i   (arena_bytes),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .action_i        (action),
    .size_bytes_i    (size_bytes),
    .address_i       (address),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .data_address_i  (data_address),
    .status_i        (status),
    .failure_count_i (failure_count),
    .error_count_o   (error_count),
    .pending_o       (pending)
  );

  // Receiver stall: quiet, random and long-stall stretches in turn
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    case ((cyc / 300) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ((cyc % 17) < 9);
    endcase
  end

  // Collect returned blocks so later requests can free or grow them
  always @(posedge clk_i) begin
    if (out_valid && !out_stall && status == ffaa_pkg::ST_OK && data_address != 0)
      live_blocks.push_back(data_address);
  end

  // Watchdog: end the run if no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Send one request; insert a random gap between bursts
  task automatic send_request(ffaa_pkg::act_e act, int unsigned sz, int unsigned adr);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid   <= 1'b1;
    action     <= act;
    size_bytes <= ffaa_pkg::SIZE_W'(sz);
    address    <= ffaa_pkg::ADDR_W'(adr);
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_arena(int unsigned bytes);
    wait_drained();
    cfg_we      <= 1'b1;
    arena_bytes <= ffaa_pkg::SIZE_W'(bytes);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    live_blocks.delete();
  endtask

  task automatic random_request();
    int unsigned r, sz, adr, idx;
    ffaa_pkg::act_e act;
    r = $urandom_range(0, 99);
    if (live_blocks.size() > 30) r = (r < 50) ? 60 : r;
    act = (r < 35) ? ffaa_pkg::ACT_ALLOC :
          (r < 50) ? ffaa_pkg::ACT_ALLOC_END :
          (r < 75) ? ffaa_pkg::ACT_FREE : ffaa_pkg::ACT_REALLOC;
    r = $urandom_range(0, 99);
    if (r < 70) sz = $urandom_range(0, 256);
    else if (r < 90) sz = $urandom_range(0, 4096);
    else if (r < 97) sz = $urandom_range(0, 65536);
    else sz = $urandom_range(0, 131071);
    r = $urandom_range(0, 99);
    if (live_blocks.size() != 0 && r < 80) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      adr = live_blocks[idx];
      if (act == ffaa_pkg::ACT_FREE || act == ffaa_pkg::ACT_REALLOC) live_blocks.delete(idx);
    end else if (r < 88) adr = 16 * $urandom_range(0, 4095);
    else if (r < 94) adr = 0;
    else adr = $urandom_range(0, 65535);
    send_request(act, sz, adr);
  endtask

  initial begin
    int unsigned arenas[6];
    arenas = '{64, 0, 131071, 1000, 65536, 272};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests on the full default arena
    send_request(ffaa_pkg::ACT_ALLOC, 0, 0);
    send_request(ffaa_pkg::ACT_ALLOC, 17, 0);
    send_request(ffaa_pkg::ACT_ALLOC_END, 16, 0);
    send_request(ffaa_pkg::ACT_ALLOC, 65536, 0);
    send_request(ffaa_pkg::ACT_ALLOC_END, 131071, 0);
    send_request(ffaa_pkg::ACT_FREE, 0, 0);
    send_request(ffaa_pkg::ACT_FREE, 0, 8);
    send_request(ffaa_pkg::ACT_FREE, 0, 100);
    send_request(ffaa_pkg::ACT_FREE, 0, 16'hFFF0);
    send_request(ffaa_pkg::ACT_FREE, 0, 48);
    send_request(ffaa_pkg::ACT_FREE, 0, 48);
    send_request(ffaa_pkg::ACT_REALLOC, 32, 0);
    send_request(ffaa_pkg::ACT_REALLOC, 16, 96);
    send_request(ffaa_pkg::ACT_REALLOC, 200, 96);
    send_request(ffaa_pkg::ACT_REALLOC, 0, 96);
    send_request(ffaa_pkg::ACT_REALLOC, 16, 96);
    send_request(ffaa_pkg::ACT_REALLOC, 16, 9);
    send_request(ffaa_pkg::ACT_REALLOC, 131071, 0);
    send_request(ffaa_pkg::ACT_REALLOC, 4000, 48);
    send_request(ffaa_pkg::ACT_ALLOC, 65535, 16'hFFFF);
    live_blocks.delete();

    for (int p = 0; p <= 6; p++) begin
      if (p > 0) write_arena(arenas[p-1]);
      repeat (PHASE_ITEMS) random_request();
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
